### rtl/core/sha1e_pkg.sv
`timescale 1ns / 1ps
// sha1e_pkg: shared types and constants of the sha-1 hash engine
// used by sha1e_round and sha1_hash_engine_core, depends on nothing

package sha1e_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_FIN,
        ST_EMIT_RD,
        ST_EMIT_WR
    } sha1e_state_t;

    // working variables a..e, element 0 is a
    typedef logic [4:0][31:0] sha1e_words_t;

    // control from the sequencer to the round datapath
    typedef struct packed {
        logic       load;
        logic [2:0] idx;
        logic       step;
        logic [6:0] rnd;
    } sha1e_rctl_t;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    localparam logic [31:0] K_CH  = 32'h5A827999;
    localparam logic [31:0] K_PAR = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
    localparam logic [31:0] K_END = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LAST_BYTE  = 6'd63;
    localparam logic [5:0] LEN_START  = 6'd56;
    localparam logic [2:0] HASH_LAST  = 3'd4;
    localparam logic [6:0] XFER_LAST  = 7'd5;
    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [6:0] SCHED_LEN  = 7'd16;
    localparam logic [6:0] ROUND_P1   = 7'd20;
    localparam logic [6:0] ROUND_P2   = 7'd40;
    localparam logic [6:0] ROUND_P3   = 7'd60;

    function automatic logic [31:0] init_word(input logic [2:0] idx);
        logic [31:0] w;
        case (idx)
            3'd0:    w = H0_INIT;
            3'd1:    w = H1_INIT;
            3'd2:    w = H2_INIT;
            3'd3:    w = H3_INIT;
            3'd4:    w = H4_INIT;
            default: w = H0_INIT;
        endcase
        return w;
    endfunction

endpackage

### rtl/core/sha1e_round.sv
`timescale 1ns / 1ps
// sha1e_round: working variables, rolling 16-word message schedule and round logic
// depends on sha1e_pkg

module sha1e_round (
    input  logic                  clk,
    input  sha1e_pkg::sha1e_rctl_t ctl,
    input  logic [31:0]           load_word,
    input  logic [31:0]           buf_word,
    output sha1e_pkg::sha1e_words_t wv
);
    import sha1e_pkg::*;

    sha1e_words_t wv_reg;
    logic [31:0]  sched_reg [0:15];

    logic [31:0] a, b, c, d, e;
    logic [31:0] x_mix, w, f, k, sum;

    always_comb
    begin
        a = wv_reg[0];
        b = wv_reg[1];
        c = wv_reg[2];
        d = wv_reg[3];
        e = wv_reg[4];
        // newest schedule word sits in tap 0
        x_mix = sched_reg[2] ^ sched_reg[7] ^ sched_reg[13] ^ sched_reg[15];
        w = (ctl.rnd < SCHED_LEN) ? buf_word : {x_mix[30:0], x_mix[31]};
        if (ctl.rnd < ROUND_P1)
        begin
            f = (b & c) | (~b & d);
            k = K_CH;
        end
        else if (ctl.rnd < ROUND_P2)
        begin
            f = b ^ c ^ d;
            k = K_PAR;
        end
        else if (ctl.rnd < ROUND_P3)
        begin
            f = (b & c) | (b & d) | (c & d);
            k = K_MAJ;
        end
        else
        begin
            f = b ^ c ^ d;
            k = K_END;
        end
        sum = {a[26:0], a[31:27]} + f + e + k + w;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            wv_reg[ctl.idx] <= load_word;
        end
        else if (ctl.step)
        begin
            wv_reg[4] <= d;
            wv_reg[3] <= c;
            wv_reg[2] <= {b[1:0], b[31:2]};
            wv_reg[1] <= a;
            wv_reg[0] <= sum;
            sched_reg[0] <= w;
            for (int j = 1; j < 16; j++)
            begin
                sched_reg[j] <= sched_reg[j-1];
            end
        end
    end

    assign wv = wv_reg;

endmodule

### rtl/core/sha1_hash_engine_core.sv
`timescale 1ns / 1ps
// sha1_hash_engine_core: sha-1 digest of a byte stream, top level
// depends on sha1e_pkg and sha1e_round
//
// usage
//  - input channel (in_valid/in_ready): one beat carries msg_byte, has_byte and
//    end_of_msg; a beat with has_byte low and end_of_msg low is a no-op
//  - output channel (out_valid/out_ready): five beats per message, digest words
//    h0..h4 with word_index 0..4, last_word high on the fifth
//  - byte beats are taken one per cycle while idle; the 64th byte of a block
//    starts compression, during which in_ready is low: chain read, 80 rounds at
//    one per cycle, chain read-modify-write
//  - the end beat pads one byte per cycle (0x80, zeros, 64-bit length) with one
//    or two compressions, then emits each word in a read and a write state through
//    the chain memory read port; in_ready stays low until the last word is loaded
//  - a stalled receiver holds the word in the output register and the engine
//    waits; the next message may start while the fifth word is still pending
//  - reset clears control state only; chain values sit behind per-entry valid
//    bits and read as the initial values until written, so no clearing pass

module sha1_hash_engine_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  msg_byte,
    input  logic        has_byte,
    input  logic        end_of_msg,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import sha1e_pkg::*;

    // sequencer state
    sha1e_state_t state_reg, state_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic [5:0]   fill_reg, fill_next;
    logic [23:0]  acc_reg, acc_next;        // partial big-endian word
    logic [63:0]  bit_cnt_reg, bit_cnt_next;
    logic         pad_pend_reg, pad_pend_next;  // message closed, padding underway
    logic         first_reg, first_next;        // 0x80 marker still to go
    logic         len_phase_reg, len_phase_next;
    logic [4:0]   chain_vld_reg, chain_vld_next;

    // output register
    logic         out_valid_reg, out_valid_next;
    logic [31:0]  digest_word_reg, digest_word_next;
    logic [2:0]   word_index_reg, word_index_next;
    logic         last_word_reg, last_word_next;

    // block buffer memory, 16 words of four message bytes
    logic [31:0]  buf_mem [0:15];
    logic         buf_we;
    logic [3:0]   buf_waddr, buf_raddr;
    logic [31:0]  buf_q_reg;

    // chain value memory, 5 words
    logic [31:0]  chain_mem [0:4];
    logic         chain_we;
    logic [31:0]  chain_wdata;
    logic [2:0]   chain_raddr;
    logic [31:0]  chain_q_reg;
    logic         chain_qv_reg;
    logic [2:0]   chain_qi_reg;
    logic [31:0]  chain_rd;

    // byte insertion
    logic         put_en;
    logic [7:0]   put_val;
    logic [2:0]   len_sel;
    logic [7:0]   len_byte;

    sha1e_rctl_t  rctl;
    sha1e_words_t wv;

    sha1e_round u_round (
        .clk       (clk),
        .ctl       (rctl),
        .load_word (chain_rd),
        .buf_word  (buf_q_reg),
        .wv        (wv)
    );

    // unwritten chain entries read as the initial hash values
    assign chain_rd = chain_qv_reg ? chain_q_reg : init_word(chain_qi_reg);

    // length byte for fill positions 56..63, most significant first
    assign len_sel  = 3'd7 - fill_reg[2:0];
    assign len_byte = bit_cnt_reg[{len_sel, 3'b000} +: 8];

    assign buf_waddr   = fill_reg[5:2];
    assign buf_raddr   = (state_reg == ST_ROUND) ? (cnt_reg[3:0] + 4'd1) : 4'd0;
    assign chain_raddr = (cnt_reg[2:0] > HASH_LAST) ? 3'd0 : cnt_reg[2:0];

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign digest_word = digest_word_reg;
    assign word_index  = word_index_reg;
    assign last_word   = last_word_reg;

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        fill_next        = fill_reg;
        acc_next         = acc_reg;
        bit_cnt_next     = bit_cnt_reg;
        pad_pend_next    = pad_pend_reg;
        first_next       = first_reg;
        len_phase_next   = len_phase_reg;
        chain_vld_next   = chain_vld_reg;
        out_valid_next   = out_valid_reg & ~out_ready;
        digest_word_next = digest_word_reg;
        word_index_next  = word_index_reg;
        last_word_next   = last_word_reg;
        buf_we           = 1'b0;
        chain_we         = 1'b0;
        chain_wdata      = chain_rd + wv[chain_qi_reg];
        put_en           = 1'b0;
        put_val          = 8'd0;
        rctl             = '0;
        rctl.idx         = chain_qi_reg;
        rctl.rnd         = cnt_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (has_byte)
                    begin
                        put_en       = 1'b1;
                        put_val      = msg_byte;
                        bit_cnt_next = bit_cnt_reg + 64'd8;
                    end
                    if (end_of_msg)
                    begin
                        pad_pend_next  = 1'b1;
                        first_next     = 1'b1;
                        len_phase_next = 1'b0;
                        state_next     = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                put_en = 1'b1;
                if (first_reg)
                begin
                    put_val    = PAD_MARK;
                    first_next = 1'b0;
                end
                else if (len_phase_reg || (fill_reg == LEN_START))
                begin
                    put_val        = len_byte;
                    len_phase_next = 1'b1;
                end
                else
                begin
                    put_val = 8'd0;
                end
            end
            ST_LOAD:
            begin
                // one chain read per cycle, the data lands in the next cycle
                rctl.load = (cnt_reg != 7'd0);
                if (cnt_reg == XFER_LAST)
                begin
                    state_next = ST_ROUND;
                    cnt_next   = 7'd0;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_ROUND:
            begin
                rctl.step = 1'b1;
                if (cnt_reg == ROUND_LAST)
                begin
                    state_next = ST_FIN;
                    cnt_next   = 7'd0;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_FIN:
            begin
                // write entry i while entry i+1 is being read
                if (cnt_reg != 7'd0)
                begin
                    chain_we                     = 1'b1;
                    chain_vld_next[chain_qi_reg] = 1'b1;
                end
                if (cnt_reg == XFER_LAST)
                begin
                    cnt_next = 7'd0;
                    if (pad_pend_reg && len_phase_reg)
                    begin
                        state_next = ST_EMIT_RD;
                    end
                    else if (pad_pend_reg)
                    begin
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_WR;
            end
            ST_EMIT_WR:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    digest_word_next = chain_rd;
                    word_index_next  = chain_qi_reg;
                    last_word_next   = (chain_qi_reg == HASH_LAST);
                    if (cnt_reg[2:0] == HASH_LAST)
                    begin
                        // reload: initial chain, empty length, no pending pad
                        chain_vld_next = '0;
                        bit_cnt_next   = '0;
                        pad_pend_next  = 1'b0;
                        len_phase_next = 1'b0;
                        first_next     = 1'b0;
                        cnt_next       = 7'd0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 7'd1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // append one byte to the block, full block starts compression
        if (put_en)
        begin
            if (fill_reg[1:0] == 2'b11)
            begin
                buf_we = 1'b1;
            end
            else
            begin
                acc_next = {acc_reg[15:0], put_val};
            end
            fill_next = fill_reg + 6'd1;
            if (fill_reg == LAST_BYTE)
            begin
                state_next = ST_LOAD;
                cnt_next   = 7'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            fill_reg      <= '0;
            bit_cnt_reg   <= '0;
            pad_pend_reg  <= 1'b0;
            first_reg     <= 1'b0;
            len_phase_reg <= 1'b0;
            chain_vld_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            fill_reg      <= fill_next;
            bit_cnt_reg   <= bit_cnt_next;
            pad_pend_reg  <= pad_pend_next;
            first_reg     <= first_next;
            len_phase_reg <= len_phase_next;
            chain_vld_reg <= chain_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        acc_reg         <= acc_next;
        digest_word_reg <= digest_word_next;
        word_index_reg  <= word_index_next;
        last_word_reg   <= last_word_next;
    end

    // block buffer memory
    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[buf_waddr] <= {acc_reg, put_val};
        end
        buf_q_reg <= buf_mem[buf_raddr];
    end

    // chain value memory
    always_ff @(posedge clk)
    begin
        if (chain_we)
        begin
            chain_mem[chain_qi_reg] <= chain_wdata;
        end
        chain_q_reg  <= chain_mem[chain_raddr];
        chain_qv_reg <= chain_vld_reg[chain_raddr];
        chain_qi_reg <= chain_raddr;
    end

`ifndef SYNTH
    // no new message beat while the current one is still being finished
    a_no_accept_while_finishing: assert property (
        @(posedge clk) disable iff (!rst_n)
        pad_pend_reg |-> !in_ready
    ) else $error("input accepted while a message is finishing");

    // digest is emitted only after the length block left the buffer empty
    a_emit_block_aligned: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT_RD) |-> (fill_reg == 6'd0) && len_phase_reg
    ) else $error("digest emission with a partially filled block");

    // last flag matches the word position
    a_last_flag: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (last_word_reg == (word_index_reg == HASH_LAST))
    ) else $error("last_word does not match word_index");

    // compression leaves the round loop exactly after the last round
    a_round_exit: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) && (cnt_reg == ROUND_LAST) |=> (state_reg == ST_FIN)
    ) else $error("round loop did not hand over to the chain update");
`endif

endmodule
